### design/dlt_pkg.sv
// Shared types, codes and defaults for the delta-list timer manager.
package dlt_pkg;

    localparam int TIMER_SLOTS_DEF = 16;

    localparam logic [2:0] MODE_CREATE = 3'd0;
    localparam logic [2:0] MODE_START  = 3'd1;
    localparam logic [2:0] MODE_STOP   = 3'd2;
    localparam logic [2:0] MODE_DELETE = 3'd3;
    localparam logic [2:0] MODE_SET    = 3'd4;
    localparam logic [2:0] MODE_READ   = 3'd5;
    localparam logic [2:0] MODE_TICK   = 3'd6;

    localparam logic KIND_REPLY  = 1'b0;
    localparam logic KIND_EVENT  = 1'b1;
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef struct packed {
        logic [2:0]  mode;
        logic [3:0]  slot_id;
        logic [31:0] count;
        logic [31:0] reload;
        logic        periodic;
    } in_word_t;

    typedef struct packed {
        logic        kind;
        logic [3:0]  timer_id_out;
        logic        status;
        logic [31:0] count_out;
        logic        last;
    } out_word_t;

    typedef struct packed {
        logic dc;
        logic rl;
        logic nx;
        logic pv;
    } store_we_t;

endpackage

### design/dlt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dlt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### design/dlt_store.sv
// Timer entry store: delta, reload and link RAMs plus the list head registers.
module dlt_store #(
    parameter int TIMER_SLOTS = dlt_pkg::TIMER_SLOTS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [$clog2(TIMER_SLOTS+1)-1:0] rd_node,
    input  dlt_pkg::store_we_t               we,
    input  logic [$clog2(TIMER_SLOTS+1)-1:0] dc_node,
    input  logic [31:0]                      dc_data,
    input  logic [$clog2(TIMER_SLOTS+1)-1:0] rl_node,
    input  logic [31:0]                      rl_data,
    input  logic [$clog2(TIMER_SLOTS+1)-1:0] nx_node,
    input  logic [$clog2(TIMER_SLOTS+1)-1:0] nx_data,
    input  logic [$clog2(TIMER_SLOTS+1)-1:0] pv_node,
    input  logic [$clog2(TIMER_SLOTS+1)-1:0] pv_data,
    output logic [31:0]                      dc_rd,
    output logic [31:0]                      rl_rd,
    output logic [$clog2(TIMER_SLOTS+1)-1:0] nx_rd,
    output logic [$clog2(TIMER_SLOTS+1)-1:0] pv_rd,
    output logic [$clog2(TIMER_SLOTS+1)-1:0] head_next,
    output logic [$clog2(TIMER_SLOTS+1)-1:0] head_prev
);
    import dlt_pkg::*;

    localparam int NW = $clog2(TIMER_SLOTS + 1);
    localparam int IW = $clog2(TIMER_SLOTS);
    localparam logic [NW-1:0] HEAD = NW'(TIMER_SLOTS);

    logic [NW-1:0] head_next_reg;
    logic [NW-1:0] head_prev_reg;
    logic          nx_ram_we;
    logic          pv_ram_we;

    assign nx_ram_we = we.nx && (nx_node != HEAD);
    assign pv_ram_we = we.pv && (pv_node != HEAD);
    assign head_next = head_next_reg;
    assign head_prev = head_prev_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_next_reg <= HEAD;
            head_prev_reg <= HEAD;
        end
        else
        begin
            if (we.nx && (nx_node == HEAD))
            begin
                head_next_reg <= nx_data;
            end
            if (we.pv && (pv_node == HEAD))
            begin
                head_prev_reg <= pv_data;
            end
        end
    end

    dlt_ram #(.WIDTH(32), .DEPTH(TIMER_SLOTS)) u_dc (
        .clk   (clk),
        .we    (we.dc),
        .waddr (IW'(dc_node)),
        .wdata (dc_data),
        .raddr (IW'(rd_node)),
        .rdata (dc_rd)
    );

    dlt_ram #(.WIDTH(32), .DEPTH(TIMER_SLOTS)) u_rl (
        .clk   (clk),
        .we    (we.rl),
        .waddr (IW'(rl_node)),
        .wdata (rl_data),
        .raddr (IW'(rd_node)),
        .rdata (rl_rd)
    );

    dlt_ram #(.WIDTH(NW), .DEPTH(TIMER_SLOTS)) u_nx (
        .clk   (clk),
        .we    (nx_ram_we),
        .waddr (IW'(nx_node)),
        .wdata (nx_data),
        .raddr (IW'(rd_node)),
        .rdata (nx_rd)
    );

    dlt_ram #(.WIDTH(NW), .DEPTH(TIMER_SLOTS)) u_pv (
        .clk   (clk),
        .we    (pv_ram_we),
        .waddr (IW'(pv_node)),
        .wdata (pv_data),
        .raddr (IW'(rd_node)),
        .rdata (pv_rd)
    );

endmodule

### design/delta_list_timer_manager.sv
// Delta-list timer manager: command sequencer over the timer entry store.
//
//   channel   signals                          payload
//   in        in_valid / in_ready / in_data    command word
//   out       out_valid / out_ready / out_data reply and expiry event words
//
// One command at a time; in_ready is high only when the sequencer is idle.
// Create and no-op commands go straight to the reply; read loads the entry
// first; start and set walk the list entry by entry, stop and delete
// unlink the entry first. A tick decrements the head delta, then removes
// each fired timer and reinserts the periodic ones.
// The output register lets the walk continue while a word waits; a stalled
// out channel holds the sequencer only when the next word is ready.
// Reset clears slot usage and the head links; no clearing pass.
module delta_list_timer_manager #(
    parameter int TIMER_SLOTS = dlt_pkg::TIMER_SLOTS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  dlt_pkg::in_word_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output dlt_pkg::out_word_t out_data
);
    import dlt_pkg::*;

    localparam int NW = $clog2(TIMER_SLOTS + 1);
    localparam int IW = $clog2(TIMER_SLOTS);
    localparam int KW = $clog2(TIMER_SLOTS + 1);
    localparam logic [NW-1:0] HEAD = NW'(TIMER_SLOTS);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_LD   = 5'd1;
    localparam logic [4:0] S_LDW  = 5'd2;
    localparam logic [4:0] S_R0   = 5'd3;
    localparam logic [4:0] S_R1   = 5'd4;
    localparam logic [4:0] S_R2   = 5'd5;
    localparam logic [4:0] S_I0   = 5'd6;
    localparam logic [4:0] S_I1   = 5'd7;
    localparam logic [4:0] S_I2   = 5'd8;
    localparam logic [4:0] S_L1   = 5'd9;
    localparam logic [4:0] S_L2   = 5'd10;
    localparam logic [4:0] S_FIN  = 5'd11;
    localparam logic [4:0] S_SETW = 5'd12;
    localparam logic [4:0] S_T0   = 5'd13;
    localparam logic [4:0] S_T1   = 5'd14;
    localparam logic [4:0] S_T2   = 5'd15;
    localparam logic [4:0] S_T3   = 5'd16;
    localparam logic [4:0] S_TP   = 5'd17;
    localparam logic [4:0] S_TEV  = 5'd18;
    localparam logic [4:0] S_REP  = 5'd19;
    localparam logic [4:0] S_OUT  = 5'd20;

    logic [4:0]       state_reg, state_next;
    logic [4:0]       ret_reg, ret_next;
    logic [4:0]       after_reg, after_next;
    logic [2:0]       mode_reg, mode_next;
    logic [NW-1:0]    t_reg, t_next;
    logic [31:0]      cnt_reg, cnt_next;
    logic [31:0]      rel_reg, rel_next;
    logic [31:0]      left_reg, left_next;
    logic [31:0]      dt_reg, dt_next;
    logic [31:0]      rlv_reg, rlv_next;
    logic [NW-1:0]    p_reg, p_next;
    logic [NW-1:0]    before_reg, before_next;
    logic [NW-1:0]    n_reg, n_next;
    logic [KW-1:0]    k_reg, k_next;
    logic [TIMER_SLOTS-1:0] used_reg, used_next;
    logic [TIMER_SLOTS-1:0] run_reg, run_next;
    logic [TIMER_SLOTS-1:0] per_reg, per_next;
    out_word_t        res_reg, res_next;
    out_word_t        out_reg, out_next;
    logic             ov_reg, ov_next;

    logic [NW-1:0]    rd_node;
    store_we_t        we;
    logic [NW-1:0]    dc_node, rl_node, nx_node, nx_data, pv_node, pv_data;
    logic [31:0]      dc_data, rl_data;
    logic [31:0]      dc_rd, rl_rd;
    logic [NW-1:0]    nx_rd, pv_rd, head_next, head_prev;

    logic             found;
    logic [IW-1:0]    free_idx;
    logic             id_ok;
    logic [IW-1:0]    in_idx;
    logic [IW-1:0]    t_idx;
    logic             accept;

    dlt_store #(.TIMER_SLOTS(TIMER_SLOTS)) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_node   (rd_node),
        .we        (we),
        .dc_node   (dc_node),
        .dc_data   (dc_data),
        .rl_node   (rl_node),
        .rl_data   (rl_data),
        .nx_node   (nx_node),
        .nx_data   (nx_data),
        .pv_node   (pv_node),
        .pv_data   (pv_data),
        .dc_rd     (dc_rd),
        .rl_rd     (rl_rd),
        .nx_rd     (nx_rd),
        .pv_rd     (pv_rd),
        .head_next (head_next),
        .head_prev (head_prev)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = ov_reg;
    assign out_data  = out_reg;
    assign in_idx    = IW'(in_data.slot_id);
    assign t_idx     = IW'(t_reg);
    assign id_ok     = (32'(in_data.slot_id) < TIMER_SLOTS) && used_reg[in_idx];

    always_comb
    begin
        found    = 1'b0;
        free_idx = '0;
        for (int i = TIMER_SLOTS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                found    = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        after_next  = after_reg;
        mode_next   = mode_reg;
        t_next      = t_reg;
        cnt_next    = cnt_reg;
        rel_next    = rel_reg;
        left_next   = left_reg;
        dt_next     = dt_reg;
        rlv_next    = rlv_reg;
        p_next      = p_reg;
        before_next = before_reg;
        n_next      = n_reg;
        k_next      = k_reg;
        used_next   = used_reg;
        run_next    = run_reg;
        per_next    = per_reg;
        res_next    = res_reg;
        out_next    = out_reg;
        ov_next     = ov_reg;
        rd_node     = t_reg;
        we          = '0;
        dc_node     = t_reg;
        dc_data     = left_reg;
        rl_node     = t_reg;
        rl_data     = rel_reg;
        nx_node     = t_reg;
        nx_data     = t_reg;
        pv_node     = t_reg;
        pv_data     = t_reg;

        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    mode_next  = in_data.mode;
                    t_next     = NW'(in_data.slot_id);
                    cnt_next   = in_data.count;
                    rel_next   = in_data.reload;
                    after_next = S_IDLE;
                    res_next   = '{KIND_REPLY, in_data.slot_id, STATUS_OK, 32'd0, 1'b1};
                    state_next = S_OUT;
                    unique case (in_data.mode)
                        MODE_CREATE:
                        begin
                            if (found)
                            begin
                                used_next[free_idx] = 1'b1;
                                run_next[free_idx]  = 1'b0;
                                per_next[free_idx]  = in_data.periodic;
                                we          = '{dc: 1'b1, rl: 1'b1, nx: 1'b1, pv: 1'b1};
                                dc_node     = NW'(free_idx);
                                dc_data     = in_data.count;
                                rl_node     = NW'(free_idx);
                                rl_data     = in_data.reload;
                                nx_node     = NW'(free_idx);
                                nx_data     = NW'(free_idx);
                                pv_node     = NW'(free_idx);
                                pv_data     = NW'(free_idx);
                                res_next.timer_id_out = 4'(free_idx);
                            end
                            else
                            begin
                                res_next.timer_id_out = 4'd0;
                                res_next.status       = STATUS_FAIL;
                            end
                        end
                        MODE_START:
                        begin
                            if (id_ok && !run_reg[in_idx])
                            begin
                                run_next[in_idx] = 1'b1;
                                ret_next   = S_REP;
                                state_next = S_LD;
                            end
                        end
                        MODE_STOP:
                        begin
                            if (id_ok && run_reg[in_idx])
                            begin
                                ret_next   = S_FIN;
                                state_next = S_R0;
                            end
                        end
                        MODE_DELETE:
                        begin
                            if (id_ok)
                            begin
                                ret_next   = S_FIN;
                                state_next = run_reg[in_idx] ? S_R0 : S_FIN;
                            end
                        end
                        MODE_SET:
                        begin
                            if (id_ok)
                            begin
                                ret_next   = S_SETW;
                                state_next = run_reg[in_idx] ? S_R0 : S_SETW;
                            end
                        end
                        MODE_READ:
                        begin
                            if (id_ok)
                            begin
                                state_next = S_LD;
                            end
                        end
                        MODE_TICK:
                        begin
                            k_next     = '0;
                            state_next = S_T0;
                        end
                        default:
                        begin
                            res_next.timer_id_out = 4'd0;
                        end
                    endcase
                end
            end
            S_LD:
            begin
                rd_node    = t_reg;
                state_next = S_LDW;
            end
            S_LDW:
            begin
                if (mode_reg == MODE_READ)
                begin
                    res_next.count_out = dc_rd;
                    state_next = S_OUT;
                end
                else
                begin
                    left_next  = dc_rd;
                    state_next = S_I0;
                end
            end
            S_R0:
            begin
                rd_node    = t_reg;
                state_next = S_R1;
            end
            S_R1:
            begin
                n_next  = nx_rd;
                dt_next = dc_rd;
                if (nx_rd == t_reg)
                begin
                    state_next = ret_reg;
                end
                else
                begin
                    we.nx      = 1'b1;
                    nx_node    = pv_rd;
                    nx_data    = nx_rd;
                    we.pv      = 1'b1;
                    pv_node    = nx_rd;
                    pv_data    = pv_rd;
                    rd_node    = nx_rd;
                    state_next = S_R2;
                end
            end
            S_R2:
            begin
                if (n_reg != HEAD)
                begin
                    we.dc   = 1'b1;
                    dc_node = n_reg;
                    dc_data = dc_rd + dt_reg;
                end
                we.nx      = 1'b1;
                nx_node    = t_reg;
                nx_data    = t_reg;
                we.pv      = 1'b1;
                pv_node    = t_reg;
                pv_data    = t_reg;
                state_next = ret_reg;
            end
            S_I0:
            begin
                if (left_reg == 32'd0)
                begin
                    state_next = ret_reg;
                end
                else
                begin
                    p_next     = head_next;
                    state_next = S_I1;
                end
            end
            S_I1:
            begin
                if (p_reg == HEAD)
                begin
                    before_next = head_prev;
                    state_next  = S_L1;
                end
                else
                begin
                    rd_node    = p_reg;
                    state_next = S_I2;
                end
            end
            S_I2:
            begin
                if (left_reg < dc_rd)
                begin
                    before_next = pv_rd;
                    we.dc       = 1'b1;
                    dc_node     = p_reg;
                    dc_data     = dc_rd - left_reg;
                    state_next  = S_L1;
                end
                else
                begin
                    left_next  = left_reg - dc_rd;
                    p_next     = nx_rd;
                    state_next = S_I1;
                end
            end
            S_L1:
            begin
                we.nx      = 1'b1;
                nx_node    = before_reg;
                nx_data    = t_reg;
                we.pv      = 1'b1;
                pv_node    = t_reg;
                pv_data    = before_reg;
                we.dc      = 1'b1;
                dc_node    = t_reg;
                dc_data    = left_reg;
                state_next = S_L2;
            end
            S_L2:
            begin
                we.nx      = 1'b1;
                nx_node    = t_reg;
                nx_data    = p_reg;
                we.pv      = 1'b1;
                pv_node    = p_reg;
                pv_data    = t_reg;
                state_next = ret_reg;
            end
            S_FIN:
            begin
                run_next[t_idx] = 1'b0;
                if (mode_reg == MODE_DELETE)
                begin
                    used_next[t_idx] = 1'b0;
                end
                state_next = S_OUT;
            end
            S_SETW:
            begin
                we.dc   = 1'b1;
                dc_node = t_reg;
                dc_data = cnt_reg;
                we.rl   = 1'b1;
                rl_node = t_reg;
                rl_data = rel_reg;
                if (run_reg[t_idx])
                begin
                    left_next  = cnt_reg;
                    ret_next   = S_REP;
                    state_next = S_I0;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_T0:
            begin
                t_next  = head_next;
                rd_node = head_next;
                state_next = (head_next == HEAD) ? S_T2 : S_T1;
            end
            S_T1:
            begin
                if (dc_rd != 32'd0)
                begin
                    we.dc   = 1'b1;
                    dc_node = t_reg;
                    dc_data = dc_rd - 32'd1;
                end
                state_next = S_T2;
            end
            S_T2:
            begin
                if ((head_next != HEAD) && (k_reg < KW'(TIMER_SLOTS)))
                begin
                    t_next     = head_next;
                    rd_node    = head_next;
                    state_next = S_T3;
                end
                else
                begin
                    res_next   = '{KIND_REPLY, 4'd0, STATUS_OK, 32'd0, 1'b1};
                    after_next = S_IDLE;
                    state_next = S_OUT;
                end
            end
            S_T3:
            begin
                if (dc_rd == 32'd0)
                begin
                    rlv_next   = rl_rd;
                    ret_next   = S_TP;
                    state_next = S_R0;
                end
                else
                begin
                    res_next   = '{KIND_REPLY, 4'd0, STATUS_OK, 32'd0, 1'b1};
                    after_next = S_IDLE;
                    state_next = S_OUT;
                end
            end
            S_TP:
            begin
                if (per_reg[t_idx])
                begin
                    we.dc      = 1'b1;
                    dc_node    = t_reg;
                    dc_data    = rlv_reg;
                    left_next  = rlv_reg;
                    ret_next   = S_TEV;
                    state_next = S_I0;
                end
                else
                begin
                    run_next[t_idx] = 1'b0;
                    state_next = S_TEV;
                end
            end
            S_TEV:
            begin
                res_next   = '{KIND_EVENT, 4'(t_reg), STATUS_OK, 32'd0, 1'b0};
                after_next = S_T2;
                k_next     = k_reg + KW'(1);
                state_next = S_OUT;
            end
            S_REP:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!ov_reg || out_ready)
                begin
                    out_next   = res_reg;
                    ov_next    = 1'b1;
                    state_next = after_reg;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
            after_reg <= S_IDLE;
            used_reg  <= '0;
            ov_reg    <= 1'b0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            after_reg <= after_next;
            used_reg  <= used_next;
            ov_reg    <= ov_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        t_reg      <= t_next;
        cnt_reg    <= cnt_next;
        rel_reg    <= rel_next;
        left_reg   <= left_next;
        dt_reg     <= dt_next;
        rlv_reg    <= rlv_next;
        p_reg      <= p_next;
        before_reg <= before_next;
        n_reg      <= n_next;
        run_reg    <= run_next;
        per_reg    <= per_next;
        res_reg    <= res_next;
        out_reg    <= out_next;
    end

endmodule
